### rtl/core/clcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the character LCD nibble expander sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_CLEAR  = 3'd1,
		OP_CMD    = 3'd2,
		OP_DATA   = 3'd3,
		OP_CURSOR = 3'd4,
		OP_CHAR   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		PH_SET    = 2'd0,
		PH_EN_HI  = 2'd1,
		PH_EN_LO  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       rs;
		logic       half;
		logic       last;
	} job_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] INIT_NIB_WAKE = 8'h30;
	localparam logic [7:0] INIT_NIB_4BIT = 8'h20;

	localparam int INIT_JOBS = 8;

	function automatic logic [7:0] init_cmd(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h28;
			2'd1: c = 8'h0c;
			2'd2: c = 8'h06;
			default: c = 8'h02;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/clcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_front
// Accepts requests and breaks each one into byte and nibble jobs for the queue.
// ----------------------------------------------------------------------------
module clcd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        op,
	input  logic [7:0]        value,
	input  logic [5:0]        column,
	input  logic              row,
	input  logic              q_full,
	output logic              q_push,
	output clcd_pkg::job_t    q_job
);
	import clcd_pkg::*;

	logic       active_q;
	op_t        op_q;
	logic [7:0] value_q;
	logic [7:0] addr_q;
	logic [2:0] idx_q;
	logic       final_job;
	logic       accept;
	logic       op_ok;

	always_comb begin
		q_job     = '0;
		final_job = 1'b1;
		unique case (op_q)
			OP_INIT: begin
				final_job = (idx_q == 3'(INIT_JOBS - 1));
				if (!idx_q[2]) begin
					q_job.half = 1'b1;
					q_job.data = (idx_q[1:0] == 2'd3) ? INIT_NIB_4BIT : INIT_NIB_WAKE;
				end else begin
					q_job.data = init_cmd(idx_q[1:0]);
				end
			end
			OP_CLEAR:  q_job.data = CMD_CLEAR;
			OP_CMD:    q_job.data = value_q;
			OP_DATA: begin
				q_job.data = value_q;
				q_job.rs   = 1'b1;
			end
			OP_CURSOR: q_job.data = addr_q;
			OP_CHAR: begin
				final_job = idx_q[0];
				if (idx_q[0]) begin
					q_job.data = value_q;
					q_job.rs   = 1'b1;
				end else begin
					q_job.data = addr_q;
				end
			end
			default: final_job = 1'b1;
		endcase
		q_job.last = final_job;
	end

	assign q_push = active_q && !q_full;
	assign busy   = active_q && !(q_push && final_job);
	assign accept = start && !busy;
	assign op_ok  = (op <= 3'(OP_CHAR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (accept) begin
			active_q <= op_ok;
			idx_q    <= '0;
		end else if (q_push) begin
			if (final_job) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(op);
			value_q <= value;
			addr_q  <= {1'b1, row, column};
		end
	end

endmodule

### rtl/core/clcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_queue
// Short job queue between the request front end and the byte sequencer.
// ----------------------------------------------------------------------------
module clcd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  clcd_pkg::job_t    push_job,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output clcd_pkg::job_t    head
);
	import clcd_pkg::*;

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

### rtl/core/clcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_back
// Expands queued jobs into expander bytes, one per cycle, with enable pulses.
// ----------------------------------------------------------------------------
module clcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              backlight_q,
	input  logic              q_empty,
	input  clcd_pkg::job_t    q_head,
	output logic              q_pop,
	output logic              strobe,
	output logic [7:0]        expander_byte,
	output logic              last
);
	import clcd_pkg::*;

	logic       active_q;
	job_t       job_q;
	logic       nib_q;
	phase_t     ph_q;
	logic       job_end;
	logic [3:0] nib;
	logic       strobe_q;
	logic [7:0] byte_q;
	logic       last_q;

	assign job_end = active_q && (ph_q == PH_EN_LO) && (job_q.half || nib_q);
	assign q_pop   = (!active_q || job_end) && !q_empty;
	assign nib     = nib_q ? job_q.data[3:0] : job_q.data[7:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			nib_q    <= 1'b0;
			ph_q     <= PH_SET;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (q_pop) begin
				active_q <= 1'b1;
				nib_q    <= 1'b0;
				ph_q     <= PH_SET;
			end else if (job_end) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				unique case (ph_q)
					PH_SET:   ph_q <= PH_EN_HI;
					PH_EN_HI: ph_q <= PH_EN_LO;
					PH_EN_LO: begin
						ph_q  <= PH_SET;
						nib_q <= 1'b1;
					end
					default:  ph_q <= PH_SET;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_head;
		byte_q <= {nib, backlight_q, (ph_q == PH_EN_HI), 1'b0, job_q.rs};
		last_q <= job_q.last && job_end;
	end

	assign strobe        = strobe_q;
	assign expander_byte = byte_q;
	assign last          = last_q;

endmodule

### rtl/core/char_lcd_nibble_expander_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_expander_sequencer
// HD44780 4-bit request sequencer driving an 8-bit I/O expander byte stream.
// ----------------------------------------------------------------------------
// Each request is a transfer on start/busy; its expander bytes leave one per
// cycle on strobe and cannot be held off, with last marking the final byte.
// A byte job gives 6 output bytes, an init nibble 3; so clear, command, data
// and set cursor give 6 bytes, char at position 12 and init 36. The output
// sequencer sets the sustained rate; the front end pushes one job per cycle
// unless the queue is full, and a four-entry job queue lets the next request
// enter while earlier bytes go out. Unused op codes are taken and dropped.
// ----------------------------------------------------------------------------
module char_lcd_nibble_expander_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] op,
	input  logic [7:0] value,
	input  logic [5:0] column,
	input  logic       row,
	input  logic       cfg_we,
	input  logic       backlight_on,
	output logic       strobe,
	output logic [7:0] expander_byte,
	output logic       last
);
	import clcd_pkg::*;

	logic backlight_q;
	logic q_full;
	logic q_push;
	job_t q_job;
	logic q_pop;
	logic q_empty;
	job_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
		end else if (cfg_we) begin
			backlight_q <= backlight_on;
		end
	end

	clcd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.value  (value),
		.column (column),
		.row    (row),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (q_job)
	);

	clcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	clcd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.backlight_q   (backlight_q),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.strobe        (strobe),
		.expander_byte (expander_byte),
		.last          (last)
	);

endmodule
